// ===== rtl/tpd_pkg.sv =====
// shared types and constants for the tree path distance block
`default_nettype none
package tpd_pkg;
    localparam int NODES_DEF  = 65536;
    localparam int LEVELS_DEF = 16;
    localparam int NODE_W     = 16;
    localparam int DIST_W     = 32;
    localparam int LVL_W      = 5;

    typedef enum logic [1:0] {
        CMD_ATTACH = 2'd0,
        CMD_ROOT   = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_ROOT, S_AT_DEP, S_AT_RD, S_AT_WR, S_AT_ZERO,
        S_Q_DB, S_Q_SW, S_Q_LIFT, S_Q_LIFT_D, S_Q_PAIR, S_Q_PX, S_Q_PY,
        S_Q_F1, S_Q_F2, S_Q_F3, S_DONE
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [LVL_W-1:0]  lvl;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] anc;
        logic [DIST_W-1:0] span;
    } tbl_req_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] depth;
    } dep_req_t;
endpackage
`default_nettype wire

// ===== rtl/tpd_ram.sv =====
// generic single-clock ram, one write port, one registered read port
`default_nettype none
module tpd_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tpd_ctrl.sv =====
// sequencer for root, attach and query commands over the lifting tables
`default_nettype none
module tpd_ctrl #(
    parameter int NODES  = tpd_pkg::NODES_DEF,
    parameter int LEVELS = tpd_pkg::LEVELS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_stall,
    input  wire logic [1:0]                  command,
    input  wire logic [tpd_pkg::NODE_W-1:0]  node_a,
    input  wire logic [tpd_pkg::NODE_W-1:0]  node_b,
    input  wire logic [tpd_pkg::NODE_W-1:0]  edge_weight,
    output tpd_pkg::tbl_req_t                tbl_req,
    output tpd_pkg::dep_req_t                dep_req,
    input  wire logic [tpd_pkg::NODE_W-1:0]  anc_rdata,
    input  wire logic [tpd_pkg::DIST_W-1:0]  dist_rdata,
    input  wire logic [tpd_pkg::NODE_W-1:0]  dep_rdata,
    input  wire logic                        res_free,
    output logic                             res_load,
    output logic                             res_answer,
    output logic [tpd_pkg::DIST_W-1:0]       res_dist
);
    import tpd_pkg::*;

    localparam logic [LVL_W-1:0] LTOP = LVL_W'(LEVELS);
    localparam logic [LVL_W-1:0] LLAST = LVL_W'(LEVELS - 1);

    state_t state_reg, state_next;

    cmd_t              cmd_reg;
    logic [NODE_W-1:0] a_reg, b_reg, w_reg;
    logic [NODE_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [NODE_W-1:0] ax_reg, ax_next, da_reg, da_next;
    logic [NODE_W-1:0] d_reg, d_next, diff_reg, diff_next;
    logic [DIST_W-1:0] sum_reg, sum_next, dx_reg, dx_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic              zero_reg, zero_next, ans_reg, ans_next;

    logic              accept, a_ok, b_ok;
    logic [NODE_W-1:0] anc_g, dep_g, dep_inc;
    logic [DIST_W-1:0] dist_g;
    logic [LVL_W-1:0]  lvl_up;

    assign accept  = cmd_valid && !cmd_stall;
    assign a_ok    = {1'b0, a_reg} < (NODE_W + 1)'(NODES);
    assign b_ok    = {1'b0, b_reg} < (NODE_W + 1)'(NODES);
    // reads of node zero return zero
    assign anc_g   = zero_reg ? '0 : anc_rdata;
    assign dist_g  = zero_reg ? '0 : dist_rdata;
    assign dep_g   = zero_reg ? '0 : dep_rdata;
    assign dep_inc = (dep_g == '1) ? dep_g : dep_g + 1'b1;
    assign lvl_up  = lvl_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(command);
            a_reg   <= node_a;
            b_reg   <= node_b;
            w_reg   <= edge_weight;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        ax_reg   <= ax_next;
        da_reg   <= da_next;
        d_reg    <= d_next;
        diff_reg <= diff_next;
        sum_reg  <= sum_next;
        dx_reg   <= dx_next;
        lvl_reg  <= lvl_next;
        zero_reg <= zero_next;
        ans_reg  <= ans_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                unique case (cmd_reg)
                    CMD_ROOT:   state_next = (a_ok && a_reg != '0) ? S_ROOT : S_DONE;
                    CMD_ATTACH: state_next = (a_ok && b_ok && a_reg != '0) ? S_AT_DEP : S_DONE;
                    CMD_QUERY:  state_next = (a_ok && b_ok) ? S_Q_DB : S_DONE;
                    default:    state_next = S_DONE;
                endcase
            end
            S_ROOT:
            begin
                if (lvl_reg == LLAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_AT_DEP:
            begin
                if (LEVELS == 1)
                begin
                    state_next = S_DONE;
                end
                else if ((dep_inc >> 1) != '0)
                begin
                    state_next = S_AT_RD;
                end
                else
                begin
                    state_next = S_AT_ZERO;
                end
            end
            S_AT_RD:    state_next = S_AT_WR;
            S_AT_WR:
            begin
                if (lvl_reg == LLAST)
                begin
                    state_next = S_DONE;
                end
                else if ((d_reg >> lvl_up) != '0)
                begin
                    state_next = S_AT_RD;
                end
                else
                begin
                    state_next = S_AT_ZERO;
                end
            end
            S_AT_ZERO:
            begin
                if (lvl_reg == LLAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_Q_DB:     state_next = S_Q_SW;
            S_Q_SW:     state_next = S_Q_LIFT;
            S_Q_LIFT:
            begin
                if (lvl_reg == LTOP)
                begin
                    state_next = S_Q_PAIR;
                end
                else if (diff_reg[lvl_reg[3:0]])
                begin
                    state_next = S_Q_LIFT_D;
                end
            end
            S_Q_LIFT_D: state_next = S_Q_LIFT;
            S_Q_PAIR:   state_next = (lvl_reg == '0 || x_reg == y_reg) ? S_Q_F1 : S_Q_PX;
            S_Q_PX:     state_next = S_Q_PY;
            S_Q_PY:     state_next = S_Q_PAIR;
            S_Q_F1:     state_next = (x_reg == y_reg) ? S_DONE : S_Q_F2;
            S_Q_F2:     state_next = S_Q_F3;
            S_Q_F3:     state_next = S_DONE;
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cmd_stall  = (state_reg != S_IDLE);
        tbl_req    = '0;
        dep_req    = '0;
        res_load   = 1'b0;
        res_answer = ans_reg;
        // attach uses the accumulator as scratch, so only answers carry it
        res_dist   = ans_reg ? sum_reg : '0;
        x_next     = x_reg;
        y_next     = y_reg;
        ax_next    = ax_reg;
        da_next    = da_reg;
        d_next     = d_reg;
        diff_next  = diff_reg;
        sum_next   = sum_reg;
        dx_next    = dx_reg;
        lvl_next   = lvl_reg;
        zero_next  = 1'b0;
        ans_next   = ans_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ans_next = 1'b0;
                sum_next = '0;
                lvl_next = '0;
            end
            S_START:
            begin
                ans_next = (cmd_reg == CMD_QUERY);
                if (cmd_reg == CMD_ATTACH)
                begin
                    dep_req.rd_en = 1'b1;
                    dep_req.node  = b_reg;
                    zero_next     = (b_reg == '0);
                end
                else if (cmd_reg == CMD_QUERY)
                begin
                    dep_req.rd_en = 1'b1;
                    dep_req.node  = a_reg;
                    zero_next     = (a_reg == '0);
                end
            end
            S_ROOT:
            begin
                tbl_req.wr_en = 1'b1;
                tbl_req.lvl   = lvl_reg;
                tbl_req.node  = a_reg;
                dep_req.wr_en = (lvl_reg == '0);
                dep_req.node  = a_reg;
                lvl_next      = lvl_up;
            end
            S_AT_DEP:
            begin
                dep_req.wr_en = 1'b1;
                dep_req.node  = a_reg;
                dep_req.depth = dep_inc;
                tbl_req.wr_en = 1'b1;
                tbl_req.node  = a_reg;
                tbl_req.anc   = b_reg;
                tbl_req.span  = DIST_W'(w_reg);
                d_next        = dep_inc;
                x_next        = b_reg;
                sum_next      = DIST_W'(w_reg);
                lvl_next      = 5'd1;
            end
            S_AT_RD:
            begin
                tbl_req.rd_en = 1'b1;
                tbl_req.lvl   = lvl_reg - 1'b1;
                tbl_req.node  = x_reg;
                zero_next     = (x_reg == '0);
            end
            S_AT_WR:
            begin
                tbl_req.wr_en = 1'b1;
                tbl_req.lvl   = lvl_reg;
                tbl_req.node  = a_reg;
                tbl_req.anc   = anc_g;
                tbl_req.span  = sum_reg + dist_g;
                x_next        = anc_g;
                sum_next      = sum_reg + dist_g;
                lvl_next      = lvl_up;
            end
            S_AT_ZERO:
            begin
                tbl_req.wr_en = 1'b1;
                tbl_req.lvl   = lvl_reg;
                tbl_req.node  = a_reg;
                lvl_next      = lvl_up;
            end
            S_Q_DB:
            begin
                da_next       = dep_g;
                dep_req.rd_en = 1'b1;
                dep_req.node  = b_reg;
                zero_next     = (b_reg == '0);
            end
            S_Q_SW:
            begin
                // deeper node goes to x
                if (da_reg < dep_g)
                begin
                    x_next    = b_reg;
                    y_next    = a_reg;
                    diff_next = dep_g - da_reg;
                end
                else
                begin
                    x_next    = a_reg;
                    y_next    = b_reg;
                    diff_next = da_reg - dep_g;
                end
                lvl_next = '0;
            end
            S_Q_LIFT:
            begin
                if (lvl_reg != LTOP && diff_reg[lvl_reg[3:0]])
                begin
                    tbl_req.rd_en = 1'b1;
                    tbl_req.lvl   = lvl_reg;
                    tbl_req.node  = x_reg;
                    zero_next     = (x_reg == '0);
                end
                else if (lvl_reg != LTOP)
                begin
                    lvl_next = lvl_up;
                end
            end
            S_Q_LIFT_D:
            begin
                sum_next = sum_reg + dist_g;
                x_next   = anc_g;
                lvl_next = lvl_up;
            end
            S_Q_PAIR:
            begin
                if (lvl_reg != '0 && x_reg != y_reg)
                begin
                    tbl_req.rd_en = 1'b1;
                    tbl_req.lvl   = lvl_reg - 1'b1;
                    tbl_req.node  = x_reg;
                    zero_next     = (x_reg == '0);
                end
            end
            S_Q_PX:
            begin
                ax_next       = anc_g;
                dx_next       = dist_g;
                tbl_req.rd_en = 1'b1;
                tbl_req.lvl   = lvl_reg - 1'b1;
                tbl_req.node  = y_reg;
                zero_next     = (y_reg == '0);
            end
            S_Q_PY:
            begin
                if (ax_reg != anc_g)
                begin
                    sum_next = sum_reg + dx_reg + dist_g;
                    x_next   = ax_reg;
                    y_next   = anc_g;
                end
                lvl_next = lvl_reg - 1'b1;
            end
            S_Q_F1:
            begin
                tbl_req.rd_en = (x_reg != y_reg);
                tbl_req.node  = x_reg;
                zero_next     = (x_reg == '0);
            end
            S_Q_F2:
            begin
                dx_next       = dist_g;
                tbl_req.rd_en = 1'b1;
                tbl_req.node  = y_reg;
                zero_next     = (y_reg == '0);
            end
            S_Q_F3:
            begin
                sum_next = sum_reg + dx_reg + dist_g;
            end
            S_DONE:
            begin
                res_load = res_free;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/tree_path_distance_lca.sv =====
// top level: lifting table memories, sequencer and result register
// one command at a time; the next beat can be taken in the cycle after the result loads
// reset clears control and the result valid flag; table contents are undefined
// until written and need no clearing pass
`default_nettype none
module tree_path_distance_lca #(
    parameter int NODES  = tpd_pkg::NODES_DEF,
    parameter int LEVELS = tpd_pkg::LEVELS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_stall,
    input  wire logic [1:0]                  command,
    input  wire logic [tpd_pkg::NODE_W-1:0]  node_a,
    input  wire logic [tpd_pkg::NODE_W-1:0]  node_b,
    input  wire logic [tpd_pkg::NODE_W-1:0]  edge_weight,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output logic                             is_answer,
    output logic [tpd_pkg::DIST_W-1:0]       path_distance
);
    import tpd_pkg::*;

    localparam int NW     = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LIW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int TBL_AW = LIW + NW;
    localparam int TBL_D  = LEVELS * (2 ** NW);

    tbl_req_t          tbl_req;
    dep_req_t          dep_req;
    logic [NODE_W-1:0] anc_rdata, dep_rdata;
    logic [DIST_W-1:0] dist_rdata, res_dist;
    logic              res_free, res_load, res_answer;
    logic [TBL_AW-1:0] tbl_addr;
    logic              res_valid_reg;

    assign tbl_addr = {tbl_req.lvl[LIW-1:0], tbl_req.node[NW-1:0]};
    assign res_free = !res_valid_reg || !res_stall;

    tpd_ctrl #(.NODES(NODES), .LEVELS(LEVELS)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .command    (command),
        .node_a     (node_a),
        .node_b     (node_b),
        .edge_weight(edge_weight),
        .tbl_req    (tbl_req),
        .dep_req    (dep_req),
        .anc_rdata  (anc_rdata),
        .dist_rdata (dist_rdata),
        .dep_rdata  (dep_rdata),
        .res_free   (res_free),
        .res_load   (res_load),
        .res_answer (res_answer),
        .res_dist   (res_dist)
    );

    tpd_ram #(.WIDTH(NODE_W), .DEPTH(TBL_D), .ADDR_W(TBL_AW)) u_anc_ram (
        .clk    (clk),
        .wr_en  (tbl_req.wr_en),
        .wr_addr(tbl_addr),
        .wr_data(tbl_req.anc),
        .rd_en  (tbl_req.rd_en),
        .rd_addr(tbl_addr),
        .rd_data(anc_rdata)
    );

    tpd_ram #(.WIDTH(DIST_W), .DEPTH(TBL_D), .ADDR_W(TBL_AW)) u_dist_ram (
        .clk    (clk),
        .wr_en  (tbl_req.wr_en),
        .wr_addr(tbl_addr),
        .wr_data(tbl_req.span),
        .rd_en  (tbl_req.rd_en),
        .rd_addr(tbl_addr),
        .rd_data(dist_rdata)
    );

    tpd_ram #(.WIDTH(NODE_W), .DEPTH(2 ** NW), .ADDR_W(NW)) u_dep_ram (
        .clk    (clk),
        .wr_en  (dep_req.wr_en),
        .wr_addr(dep_req.node[NW-1:0]),
        .wr_data(dep_req.depth),
        .rd_en  (dep_req.rd_en),
        .rd_addr(dep_req.node[NW-1:0]),
        .rd_data(dep_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            is_answer     <= res_answer;
            path_distance <= res_dist;
        end
    end

    assign res_valid = res_valid_reg;
endmodule
`default_nettype wire

// ===== rtl/tpd_check.sv =====
// port-level checker for the tree path distance block, bound to the top level
`default_nettype none
module tpd_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cmd_valid,
    input wire logic        cmd_stall,
    input wire logic [1:0]  command,
    input wire logic [15:0] node_a,
    input wire logic [15:0] node_b,
    input wire logic [15:0] edge_weight,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic        is_answer,
    input wire logic [31:0] path_distance
);
    // a held result beat stays
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result beat dropped while stalled");

    // one command at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command taken while busy");

    // only answers carry a distance
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !is_answer |-> path_distance == 32'd0)
        else $error("non-answer beat with distance");

    // a result cannot appear the cycle after a command is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && !res_valid |=> !res_valid)
        else $error("result too early");
endmodule

bind tree_path_distance_lca tpd_check u_check (.*);
`default_nettype wire
